### hw/rtl/pcosc_pkg.sv
// Shared types and constants of the phasor cascade oscillator.
// Used by every module of the block; depends on nothing.
package pcosc_pkg;

    localparam int CHANNELS_DEF  = 8;
    localparam int ORDER_DEF     = 3;
    localparam int FRAC_BITS_DEF = 22;

    localparam int CH_W      = 3;
    localparam int OD_W      = 2;
    localparam int IO_W      = 24;
    localparam int CFG_W     = 8;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic valid;
        logic emit;
        logic proc;
        logic unity;
        logic last;
        logic renorm;
    } t_tag;

endpackage

### hw/rtl/phasor_cascade_oscillator_unit.sv
// Phasor cascade oscillator. A load word writes one store slot; the input stays ready.
// A tick word walks the store, one slot per phasor plus one per channel, then waits for
// the update pipeline to drain before it returns to idle; output stalls hold the walk at
// each channel's first slot. The store's single read port sets this slot-by-slot walk.
// Reset (synchronous, active low) clears control, tick count and interval; the store
// keeps no reset value and gets no clearing pass.
module phasor_cascade_oscillator_unit #(
    parameter int CHANNELS  = pcosc_pkg::CHANNELS_DEF,
    parameter int ORDER     = pcosc_pkg::ORDER_DEF,
    parameter int FRAC_BITS = pcosc_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // channel[2:0], order[4:3], real_part[28:5], imag_part[52:29], zero fill
    input  logic [pcosc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // action
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // out_channel[2:0], cosine[26:3], sine[50:27], zero fill
    output logic [pcosc_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,
    input  logic                            i_cfg_we,
    input  logic [pcosc_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import pcosc_pkg::*;

    localparam int W  = FRAC_BITS + 2;
    localparam int CB = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OB = $clog2(ORDER + 1);
    localparam int AW = CB + OB;

    logic            ld_we;
    logic [AW-1:0]   ld_addr;
    logic [2*W-1:0]  ld_data;
    logic            up_we;
    logic [AW-1:0]   up_addr;
    logic [2*W-1:0]  up_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [2*W-1:0]  rd_data;
    t_tag            s1_tag;
    logic [AW-1:0]   s1_waddr;
    logic            math_busy;

    pcosc_ctrl #(
        .CHANNELS  (CHANNELS),
        .ORDER     (ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_math_busy (math_busy),
        .o_ld_we     (ld_we),
        .o_ld_addr   (ld_addr),
        .o_ld_data   (ld_data),
        .o_re        (rd_en),
        .o_raddr     (rd_addr),
        .i_rdata     (rd_data),
        .o_tag       (s1_tag),
        .o_waddr     (s1_waddr)
    );

    pcosc_store #(
        .DATA_W (2 * W),
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ld_we   (ld_we),
        .i_ld_addr (ld_addr),
        .i_ld_data (ld_data),
        .i_up_we   (up_we),
        .i_up_addr (up_addr),
        .i_up_data (up_data),
        .i_re      (rd_en),
        .i_raddr   (rd_addr),
        .o_rdata   (rd_data)
    );

    pcosc_math #(
        .CHANNELS  (CHANNELS),
        .ORDER     (ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (s1_tag),
        .i_waddr (s1_waddr),
        .i_rdata (rd_data),
        .o_we    (up_we),
        .o_waddr (up_addr),
        .o_wdata (up_data),
        .o_busy  (math_busy)
    );

endmodule

### hw/rtl/pcosc_store.sv
// Phasor store: one write port, one read port with a registered read.
// Uses pcosc_pkg for default sizes.
module pcosc_store #(
    parameter int DATA_W = 2 * (pcosc_pkg::FRAC_BITS_DEF + 2),
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_ld_we,
    input  logic [ADDR_W-1:0] i_ld_addr,
    input  logic [DATA_W-1:0] i_ld_data,
    input  logic              i_up_we,
    input  logic [ADDR_W-1:0] i_up_addr,
    input  logic [DATA_W-1:0] i_up_data,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    import pcosc_pkg::*;

    logic [DATA_W-1:0] mem [0:(2**ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_up_we) begin
            mem[i_up_addr] <= i_up_data;
        end else if (i_ld_we) begin
            mem[i_ld_addr] <= i_ld_data;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pcosc_math.sv
// Update pipeline: cascade product, then optional renormalization, then write-back.
// Uses pcosc_pkg for the stage tag; fed by the store read port and the sequencer.
module pcosc_math #(
    parameter int CHANNELS  = pcosc_pkg::CHANNELS_DEF,
    parameter int ORDER     = pcosc_pkg::ORDER_DEF,
    parameter int FRAC_BITS = pcosc_pkg::FRAC_BITS_DEF,
    localparam int W  = FRAC_BITS + 2,
    localparam int CB = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int OB = $clog2(ORDER + 1),
    localparam int AW = CB + OB
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcosc_pkg::t_tag   i_tag,
    input  logic [AW-1:0]     i_waddr,
    input  logic [2*W-1:0]    i_rdata,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [2*W-1:0]    o_wdata,
    output logic              o_busy
);
    import pcosc_pkg::*;

    localparam int PW = 2 * W;
    localparam int SW = PW + 1;
    localparam int MW = W + 3;
    localparam logic signed [SW-1:0] HALF   = $signed(SW'(1) << (FRAC_BITS - 1));
    localparam logic signed [SW-1:0] PMAX_S = $signed((SW'(1) << (W - 1)) - SW'(1));
    localparam logic signed [W-1:0]  UNITY  = $signed(W'(1) << FRAC_BITS);
    localparam logic signed [MW-1:0] THREE  = $signed(MW'(3) << FRAC_BITS);

    function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] x);
        return (x + HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] y;
        if (x > PMAX_S) begin
            y = PMAX_S;
        end else if (x < -PMAX_S) begin
            y = -PMAX_S;
        end else begin
            y = x;
        end
        return y[W-1:0];
    endfunction

    logic [2*W-1:0]         r_prev;
    logic [7:1]             r_v;
    logic [6:1]             r_rn;
    logic [AW-1:0]          r_ad [1:7];

    logic signed [PW-1:0]   r_rr, r_ii, r_ri, r_ir;
    logic signed [W-1:0]    r_w2re, r_w2im;
    logic signed [PW-1:0]   r_sqre, r_sqim;
    logic signed [W-1:0]    r_w3re, r_w3im;
    logic signed [MW-1:0]   r_m2;
    logic signed [W-1:0]    r_w4re, r_w4im;
    logic signed [W-1:0]    r_f;
    logic signed [W-1:0]    r_w5re, r_w5im;
    logic signed [PW-1:0]   r_pre, r_pim;
    logic signed [W-1:0]    r_w6re, r_w6im;
    logic signed [W-1:0]    r_ore, r_oim;

    logic signed [W-1:0]    a_re, a_im, b_re, b_im;
    logic                   n_v1;
    logic signed [W-1:0]    n_w2re, n_w2im;
    logic signed [MW-1:0]   n_m2;
    logic signed [MW-1:0]   n_fsum;
    logic signed [W-1:0]    n_f;
    logic signed [W-1:0]    n_ore, n_oim;

    always_comb begin
        a_re   = r_prev[W-1:0];
        a_im   = r_prev[2*W-1:W];
        b_re   = i_tag.unity ? UNITY : i_rdata[W-1:0];
        b_im   = i_tag.unity ? W'(0) : i_rdata[2*W-1:W];
        n_v1   = i_tag.valid && i_tag.proc;
        n_w2re = sat_w(rnd(SW'(r_rr) - SW'(r_ii)));
        n_w2im = sat_w(rnd(SW'(r_ri) + SW'(r_ir)));
        n_m2   = MW'(rnd(SW'(r_sqre) + SW'(r_sqim)));
        n_fsum = THREE - r_m2;
        n_f    = sat_w(SW'((n_fsum + MW'(1)) >>> 1));
        n_ore  = r_rn[6] ? sat_w(rnd(SW'(r_pre))) : r_w6re;
        n_oim  = r_rn[6] ? sat_w(rnd(SW'(r_pim))) : r_w6im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:1], n_v1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.valid && !i_tag.unity) begin
            r_prev <= i_rdata;
        end
        r_rn  <= {r_rn[5:1], i_tag.renorm};
        r_ad[1] <= i_waddr;
        for (int i = 2; i <= 7; i++) begin
            r_ad[i] <= r_ad[i-1];
        end

        r_rr <= PW'(a_re) * PW'(b_re);
        r_ii <= PW'(a_im) * PW'(b_im);
        r_ri <= PW'(a_re) * PW'(b_im);
        r_ir <= PW'(a_im) * PW'(b_re);

        r_w2re <= n_w2re;
        r_w2im <= n_w2im;

        r_sqre <= PW'(r_w2re) * PW'(r_w2re);
        r_sqim <= PW'(r_w2im) * PW'(r_w2im);
        r_w3re <= r_w2re;
        r_w3im <= r_w2im;

        r_m2   <= n_m2;
        r_w4re <= r_w3re;
        r_w4im <= r_w3im;

        r_f    <= n_f;
        r_w5re <= r_w4re;
        r_w5im <= r_w4im;

        r_pre  <= PW'(r_w5re) * PW'(r_f);
        r_pim  <= PW'(r_w5im) * PW'(r_f);
        r_w6re <= r_w5re;
        r_w6im <= r_w5im;

        r_ore <= n_ore;
        r_oim <= n_oim;
    end

    assign o_we    = r_v[7];
    assign o_waddr = r_ad[7];
    assign o_wdata = {r_oim, r_ore};
    assign o_busy  = |r_v;

endmodule

### hw/rtl/pcosc_ctrl.sv
// Sequencer: load decode, tick walk over the store, tick counter and output register.
// Uses pcosc_pkg for states, tags and field widths.
module pcosc_ctrl #(
    parameter int CHANNELS  = pcosc_pkg::CHANNELS_DEF,
    parameter int ORDER     = pcosc_pkg::ORDER_DEF,
    parameter int FRAC_BITS = pcosc_pkg::FRAC_BITS_DEF,
    localparam int W  = FRAC_BITS + 2,
    localparam int CB = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int OB = $clog2(ORDER + 1),
    localparam int AW = CB + OB
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [pcosc_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [pcosc_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,
    input  logic                            i_cfg_we,
    input  logic [pcosc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                            i_math_busy,
    output logic                            o_ld_we,
    output logic [AW-1:0]                   o_ld_addr,
    output logic [2*W-1:0]                  o_ld_data,
    output logic                            o_re,
    output logic [AW-1:0]                   o_raddr,
    input  logic [2*W-1:0]                  i_rdata,
    output pcosc_pkg::t_tag                 o_tag,
    output logic [AW-1:0]                   o_waddr
);
    import pcosc_pkg::*;

    localparam int SB = $clog2(ORDER + 2);
    localparam int XW = 34;
    localparam logic signed [XW-1:0] PMAX_X = $signed((XW'(1) << (W - 1)) - XW'(1));
    localparam logic signed [XW-1:0] OMAX_X = $signed((XW'(1) << (IO_W - 1)) - XW'(1));

    function automatic logic signed [XW-1:0] clip(input logic signed [XW-1:0] v,
                                                 input logic signed [XW-1:0] lim);
        logic signed [XW-1:0] y;
        if (v > lim) begin
            y = lim;
        end else if (v < -lim) begin
            y = -lim;
        end else begin
            y = v;
        end
        return y;
    endfunction

    t_state                r_state, n_state;
    logic [CB-1:0]         r_ch, n_ch;
    logic [SB-1:0]         r_slot, n_slot;
    logic [CFG_W-1:0]      r_interval;
    logic [CFG_W-1:0]      r_tick, n_tick;
    logic                  r_renorm, n_renorm;
    t_tag                  r_tag, n_tag;
    logic [CB-1:0]         r_s1_ch, n_s1_ch;
    logic [AW-1:0]         r_s1_waddr, n_s1_waddr;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;
    logic                  r_out_last;

    logic [4:0]            ld_ch;
    logic [2:0]            ld_od;
    logic signed [XW-1:0]  ld_re, ld_im;
    logic signed [XW-1:0]  em_re, em_im;
    logic                  out_free;
    logic                  accept;
    logic                  slot_end;
    logic                  ch_end;

    always_comb begin
        ld_ch     = 5'(i_s_tdata[CH_W-1:0]);
        ld_od     = 3'(i_s_tdata[CH_W+OD_W-1:CH_W]);
        ld_re     = clip(XW'($signed(i_s_tdata[CH_W+OD_W+IO_W-1:CH_W+OD_W])), PMAX_X);
        ld_im     = clip(XW'($signed(i_s_tdata[CH_W+OD_W+2*IO_W-1:CH_W+OD_W+IO_W])), PMAX_X);
        accept    = i_s_tvalid && o_s_tready;
        o_ld_we   = accept && (i_s_tuser == ACT_LOAD) && (ld_ch < 5'(CHANNELS))
                    && (ld_od <= 3'(ORDER));
        o_ld_addr = {ld_ch[CB-1:0], ld_od[OB-1:0]};
        o_ld_data = {ld_im[W-1:0], ld_re[W-1:0]};
        em_re     = clip(XW'($signed(i_rdata[W-1:0])), OMAX_X);
        em_im     = clip(XW'($signed(i_rdata[2*W-1:W])), OMAX_X);
    end

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        n_slot     = r_slot;
        n_tick     = r_tick;
        n_renorm   = r_renorm;
        n_tag      = '0;
        n_s1_ch    = r_ch;
        n_s1_waddr = {r_ch, OB'(r_slot - SB'(1))};
        o_re       = 1'b0;
        o_raddr    = {r_ch, r_slot[OB-1:0]};
        o_s_tready = (r_state == ST_IDLE);
        out_free   = !r_out_valid || i_m_tready;
        slot_end   = (r_slot == SB'(ORDER + 1));
        ch_end     = (r_ch == CB'(CHANNELS - 1));
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_s_tuser == ACT_TICK)) begin
                    n_state = ST_RUN;
                    n_ch    = '0;
                    n_slot  = '0;
                    if (r_interval == '0) begin
                        n_renorm = 1'b0;
                    end else if ({1'b0, r_tick} + 9'd1 >= {1'b0, r_interval}) begin
                        n_renorm = 1'b1;
                        n_tick   = '0;
                    end else begin
                        n_renorm = 1'b0;
                        n_tick   = r_tick + CFG_W'(1);
                    end
                end
            end
            ST_RUN: begin
                if ((r_slot != '0) || out_free) begin
                    n_tag.valid  = 1'b1;
                    n_tag.emit   = (r_slot == '0);
                    n_tag.proc   = (r_slot != '0);
                    n_tag.unity  = slot_end;
                    n_tag.last   = ch_end;
                    n_tag.renorm = r_renorm;
                    o_re         = !slot_end;
                    if (slot_end) begin
                        n_slot = '0;
                        if (ch_end) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_ch = r_ch + CB'(1);
                        end
                    end else begin
                        n_slot = r_slot + SB'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_tag.valid && !i_math_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_slot      <= '0;
            r_interval  <= '0;
            r_tick      <= '0;
            r_renorm    <= 1'b0;
            r_tag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_slot   <= n_slot;
            r_tick   <= n_tick;
            r_renorm <= n_renorm;
            r_tag    <= n_tag;
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (r_tag.valid && r_tag.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ch    <= n_s1_ch;
        r_s1_waddr <= n_s1_waddr;
        if (r_tag.valid && r_tag.emit) begin
            r_out_data <= {(M_TDATA_W - CH_W - 2 * IO_W)'(0), em_im[IO_W-1:0],
                           em_re[IO_W-1:0], CH_W'(r_s1_ch)};
            r_out_last <= r_tag.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_tag      = r_tag;
    assign o_waddr    = r_s1_waddr;

endmodule

### hw/rtl/pcosc_checker.sv
// Port-level checks of the phasor cascade oscillator and their bind to the top level.
// Uses pcosc_pkg for port widths.
module pcosc_checker #(
    parameter int CHANNELS = pcosc_pkg::CHANNELS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [pcosc_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic                            o_m_tlast
);
    import pcosc_pkg::*;

    logic [4:0] r_exp;
    logic       out_acc;

    assign out_acc = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (out_acc) begin
            r_exp <= o_m_tlast ? 5'd0 : r_exp + 5'd1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (o_m_tdata[CH_W-1:0] == r_exp[CH_W-1:0])
                    && (o_m_tlast == (r_exp == 5'(CHANNELS - 1))))
        else $error("output channel order or last flag wrong");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == ACT_TICK) |=> !o_s_tready)
        else $error("input taken while a tick is in progress");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == ACT_LOAD) |=> o_s_tready)
        else $error("load word did not leave the input ready");

endmodule

bind phasor_cascade_oscillator_unit pcosc_checker #(.CHANNELS(CHANNELS)) u_pcosc_checker (.*);

### test/phasor_cascade_oscillator_unit_tb.sv
// Self-checking testbench of the phasor cascade oscillator: load and tick words,
// checked against a built-in fixed-point predictor over several renorm intervals.
// Depends on pcosc_pkg and phasor_cascade_oscillator_unit.
module phasor_cascade_oscillator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcosc_pkg::*;

    localparam int     NCH          = CHANNELS_DEF;
    localparam int     NORD         = ORDER_DEF;
    localparam int     FB           = FRAC_BITS_DEF;
    localparam longint WORD_MAX     = (longint'(1) << (FB + 1)) - 1;
    localparam longint SAMPLE_MAX   = 64'sd8388607;
    localparam longint UNIT         = longint'(1) << FB;
    localparam int     DRAIN_CYCLES = 120;

    typedef struct {
        logic            act;
        logic [CH_W-1:0] ch;
        logic [OD_W-1:0] od;
        logic [IO_W-1:0] re;
        logic [IO_W-1:0] im;
    } t_osc_word;

    typedef struct {
        logic [CH_W-1:0] ch;
        logic [IO_W-1:0] cosv;
        logic [IO_W-1:0] sinv;
        logic            last;
    } t_sample;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    t_osc_word word_q[$];
    t_osc_word bus_word;
    t_sample   sample_q[$];
    int        words_outstanding = 0;
    int        send_idle_pct     = 0;
    int        recv_stall_pct    = 0;
    int        errors            = 0;

    longint    ph_re[NCH][NORD+1];
    longint    ph_im[NCH][NORD+1];
    int        tick_cnt          = 0;
    int        renorm_int        = 0;

    phasor_cascade_oscillator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint rnd_shift(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    task automatic renorm_phasor(inout longint re, inout longint im);
        longint m2;
        longint f;
        m2 = rnd_shift(re * re + im * im, FB);
        f  = sat(rnd_shift(3 * UNIT - m2, 1), WORD_MAX);
        re = sat(rnd_shift(re * f, FB), WORD_MAX);
        im = sat(rnd_shift(im * f, FB), WORD_MAX);
    endtask

    task automatic predict_word(input t_osc_word w);
        t_sample s;
        longint  ar, ai, br, bi;
        if (w.act == ACT_LOAD) begin
            ph_re[w.ch][w.od] = sat(longint'($signed(w.re)), WORD_MAX);
            ph_im[w.ch][w.od] = sat(longint'($signed(w.im)), WORD_MAX);
        end else begin
            for (int c = 0; c < NCH; c++) begin
                s.ch   = CH_W'(c);
                s.cosv = IO_W'(sat(ph_re[c][0], SAMPLE_MAX));
                s.sinv = IO_W'(sat(ph_im[c][0], SAMPLE_MAX));
                s.last = (c == NCH - 1);
                sample_q.push_back(s);
            end
            for (int m = 0; m < NORD; m++) begin
                for (int c = 0; c < NCH; c++) begin
                    ar = ph_re[c][m];
                    ai = ph_im[c][m];
                    br = ph_re[c][m+1];
                    bi = ph_im[c][m+1];
                    ph_re[c][m] = sat(rnd_shift(ar * br - ai * bi, FB), WORD_MAX);
                    ph_im[c][m] = sat(rnd_shift(ar * bi + ai * br, FB), WORD_MAX);
                end
            end
            if (renorm_int != 0) begin
                if (tick_cnt + 1 >= renorm_int) begin
                    for (int m = 0; m <= NORD; m++)
                        for (int c = 0; c < NCH; c++)
                            renorm_phasor(ph_re[c][m], ph_im[c][m]);
                    tick_cnt = 0;
                end else begin
                    tick_cnt = (tick_cnt + 1) & 8'hFF;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_word(bus_word);
                words_outstanding--;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    bus_word = word_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {3'b000, bus_word.im, bus_word.re, bus_word.od, bus_word.ch};
                    i_s_tuser  <= bus_word.act;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_sample got;
        t_sample want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.ch   = o_m_tdata[2:0];
                got.cosv = o_m_tdata[26:3];
                got.sinv = o_m_tdata[50:27];
                got.last = o_m_tlast;
                if (sample_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected sample: ch %0d cos %0d sin %0d last %0b",
                                 got.ch, $signed(got.cosv), $signed(got.sinv), got.last);
                end else begin
                    want = sample_q.pop_front();
                    if (got.ch !== want.ch || got.cosv !== want.cosv ||
                        got.sinv !== want.sinv || got.last !== want.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: expected ch %0d cos %0d sin %0d last %0b",
                                     want.ch, $signed(want.cosv), $signed(want.sinv),
                                     want.last);
                            $display("          got ch %0d cos %0d sin %0d last %0b",
                                     got.ch, $signed(got.cosv), $signed(got.sinv), got.last);
                        end
                    end
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_osc_word load_word(int ch, int od, logic [IO_W-1:0] re,
                                            logic [IO_W-1:0] im);
        t_osc_word w;
        w.act = ACT_LOAD;
        w.ch  = CH_W'(ch);
        w.od  = OD_W'(od);
        w.re  = re;
        w.im  = im;
        return w;
    endfunction

    function automatic t_osc_word unit_load(int ch, int od);
        real a;
        real mag;
        a   = $urandom_range(62831) / 10000.0;
        mag = ($urandom_range(200) + 900) / 1000.0;
        return load_word(ch, od, IO_W'($rtoi($cos(a) * mag * 4194304.0)),
                         IO_W'($rtoi($sin(a) * mag * 4194304.0)));
    endfunction

    function automatic t_osc_word tick_word();
        t_osc_word w;
        w.act = ACT_TICK;
        w.ch  = CH_W'($urandom);
        w.od  = OD_W'($urandom);
        w.re  = IO_W'($urandom);
        w.im  = IO_W'($urandom);
        return w;
    endfunction

    function automatic t_osc_word random_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return tick_word();
        if (roll < 85) return unit_load($urandom_range(NCH - 1), $urandom_range(NORD));
        return load_word($urandom_range(NCH - 1), $urandom_range(NORD),
                         IO_W'($urandom), IO_W'($urandom));
    endfunction

    task automatic push_word(input t_osc_word w);
        word_q.push_back(w);
        words_outstanding++;
    endtask

    task automatic write_interval(input int v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(v);
        renorm_int  = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        while (words_outstanding != 0 || sample_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int intervals[5];
        int send_pct[5];
        int recv_pct[5];
        intervals = '{1, 255, 3, 0, 0};
        send_pct  = '{70, 0, 23, 0, 23};
        recv_pct  = '{0, 70, 23, 0, 23};
        intervals[4] = $urandom_range(2, 254);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_interval(0);
        for (int c = 0; c < NCH; c++)
            for (int m = 0; m <= NORD; m++)
                push_word(unit_load(c, m));

        push_word(load_word(0, 0, 24'h7FFFFF, 24'h7FFFFF));
        push_word(load_word(1, 0, 24'h800000, 24'h800000));
        push_word(load_word(2, 1, 24'h800000, 24'h7FFFFF));
        push_word(load_word(3, 3, 24'h000000, 24'h000000));
        push_word(load_word(4, 0, 24'h7FFFFF, 24'h800000));
        push_word(load_word(5, 2, 24'h400000, 24'h000000));
        push_word(load_word(6, 1, 24'h000000, 24'hC00000));
        push_word(tick_word());
        push_word(tick_word());
        push_word(load_word(7, 0, 24'h800001, 24'h000001));
        push_word(tick_word());
        push_word(load_word(0, 1, 24'hFFFFFF, 24'h7FFFFF));
        push_word(load_word(1, 2, 24'h7FFFFF, 24'hFFFFFF));
        push_word(tick_word());
        push_word(tick_word());
        push_word(tick_word());
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            write_interval(intervals[p]);
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            for (int c = 0; c < NCH; c++)
                for (int m = 0; m <= NORD; m++)
                    if ($urandom_range(7) == 0) push_word(unit_load(c, m));
            for (int k = 0; k < 9; k++)
                push_word(random_word());
            wait_idle();
        end

        if (errors == 0 && sample_q.size() == 0) begin
            $display("phasor_cascade_oscillator_unit_tb OK");
        end else begin
            $display("phasor_cascade_oscillator_unit_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("phasor_cascade_oscillator_unit_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pcosc_pkg.sv
hw/rtl/pcosc_store.sv
hw/rtl/pcosc_math.sv
hw/rtl/pcosc_ctrl.sv
hw/rtl/phasor_cascade_oscillator_unit.sv
hw/rtl/pcosc_checker.sv
test/phasor_cascade_oscillator_unit_tb.sv
